/* rtl/rdt_pkg.sv */
// shared types and constants for the reuse distance tracker
`default_nettype none

package rdt_pkg;

  localparam int KEY_W  = 32;
  localparam int IDX_W  = 31;
  localparam int GAP_W  = 32;
  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_VARIABLE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CONSTANT = 3'd3;

  localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};
  localparam logic [GAP_W-1:0] GAP_NONE  = {GAP_W{1'b1}};

  localparam logic [1:0] HINT_LOW  = 2'd0;
  localparam logic [1:0] HINT_MID  = 2'd1;
  localparam logic [1:0] HINT_HIGH = 2'd2;

  // operand currently being looked up
  typedef enum logic [1:0] {
    OP_SRC1,
    OP_SRC2,
    OP_DEST,
    OP_END
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_READ,
    ST_CMP,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic next_op;
    logic clr_ptr;
    logic inc_ptr;
    logic rd;
    logic hit;
    logic miss;
    logic finish;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic op_end;
    logic op_var;
    logic ptr_end;
    logic key_match;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/rdt_ctrl.sv */
// controller state machine for the reuse distance tracker
`default_nettype none

module rdt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rdt_pkg::dp_status_t status,
  output rdt_pkg::dp_cmd_t    cmd
);
  import rdt_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        priority if (status.op_end) begin
          state_next = ST_DONE;
        end else if (status.op_var) begin
          cmd.clr_ptr = 1'b1;
          state_next  = ST_READ;
        end else begin
          cmd.next_op = 1'b1;
        end
      end
      ST_READ: begin
        if (status.ptr_end) begin
          cmd.miss    = 1'b1;
          cmd.next_op = 1'b1;
          state_next  = ST_PICK;
        end else begin
          cmd.rd     = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (status.key_match) begin
          cmd.hit     = 1'b1;
          cmd.next_op = 1'b1;
          state_next  = ST_PICK;
        end else begin
          cmd.inc_ptr = 1'b1;
          state_next  = ST_READ;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/rdt_datapath.sv */
// key table, scan pointer, counters and result registers
`default_nettype none

module rdt_datapath #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rdt_pkg::dp_cmd_t             cmd,
  output rdt_pkg::dp_status_t          status,
  input  logic [rdt_pkg::KIND_W-1:0]   src1_kind,
  input  logic [rdt_pkg::KEY_W-1:0]    src1_key,
  input  logic [rdt_pkg::KIND_W-1:0]   src2_kind,
  input  logic [rdt_pkg::KEY_W-1:0]    src2_key,
  input  logic                         dest_is_variable,
  input  logic [rdt_pkg::KEY_W-1:0]    dest_key,
  output logic                         done,
  output logic                         access_class,
  output logic [1:0]                   reuse_class,
  output logic signed [rdt_pkg::GAP_W-1:0] reuse_gap,
  output logic                         table_full
);
  import rdt_pkg::*;

  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);

  logic [KEY_W-1:0] key_mem  [TABLE_ENTRIES];
  logic [IDX_W-1:0] last_mem [TABLE_ENTRIES];

  logic [KEY_W-1:0] key1;
  logic [KEY_W-1:0] key2;
  logic [KEY_W-1:0] keyd;
  logic             var1;
  logic             var2;
  logic             vard;
  logic             acc;
  logic [1:0]       reuse;
  logic [GAP_W-1:0] gap;
  logic             dropped;
  logic [KEY_W-1:0] rd_key;
  logic [IDX_W-1:0] rd_last;

  op_t              op;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] used;
  logic [IDX_W-1:0] idx;

  logic [KEY_W-1:0]  cur_key;
  logic              cur_var;
  logic              full;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [IDX_W-1:0]  span;
  logic              new_v1;
  logic              new_v2;
  logic [1:0]        new_reuse;

  // operand select
  always_comb begin
    unique case (op)
      OP_SRC1: begin
        cur_key = key1;
        cur_var = var1;
      end
      OP_SRC2: begin
        cur_key = key2;
        cur_var = var2;
      end
      OP_DEST: begin
        cur_key = keyd;
        cur_var = vard;
      end
      OP_END: begin
        cur_key = keyd;
        cur_var = 1'b0;
      end
      default: begin
        cur_key = keyd;
        cur_var = 1'b0;
      end
    endcase
  end

  assign full    = (used == CNT_W'(TABLE_ENTRIES));
  assign span    = idx - rd_last;
  assign mem_we  = cmd.hit | (cmd.miss & ~full);
  assign wr_addr = cmd.hit ? ptr[ADDR_W-1:0] : used[ADDR_W-1:0];

  assign status.op_end    = (op == OP_END);
  assign status.op_var    = cur_var;
  assign status.ptr_end   = (ptr == used);
  assign status.key_match = (rd_key == cur_key);

  // classes of the incoming request
  assign new_v1 = (src1_kind == KIND_VARIABLE);
  assign new_v2 = (src2_kind == KIND_VARIABLE);
  always_comb begin
    priority if (new_v1 || new_v2) begin
      new_reuse = HINT_HIGH;
    end else if (src1_kind == KIND_CONSTANT && src2_kind == KIND_CONSTANT) begin
      new_reuse = HINT_LOW;
    end else begin
      new_reuse = HINT_MID;
    end
  end

  // key table: one registered read, one write; a hit rewrites its own key
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_key  <= key_mem[ptr[ADDR_W-1:0]];
      rd_last <= last_mem[ptr[ADDR_W-1:0]];
    end
    if (mem_we) begin
      key_mem[wr_addr]  <= cur_key;
      last_mem[wr_addr] <= idx;
    end
  end

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      op   <= OP_END;
      ptr  <= '0;
      used <= '0;
      idx  <= '0;
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.load) begin
        op <= OP_SRC1;
      end else if (cmd.next_op) begin
        unique case (op)
          OP_SRC1: op <= OP_SRC2;
          OP_SRC2: op <= OP_DEST;
          OP_DEST: op <= OP_END;
          OP_END:  op <= OP_END;
          default: op <= OP_END;
        endcase
      end
      if (cmd.clr_ptr) begin
        ptr <= '0;
      end else if (cmd.inc_ptr) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.miss && !full) begin
        used <= used + 1'b1;
      end
      if (cmd.finish && idx != INDEX_MAX) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // request and result registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key1    <= src1_key;
      key2    <= src2_key;
      keyd    <= dest_key;
      var1    <= new_v1;
      var2    <= new_v2;
      vard    <= dest_is_variable;
      acc     <= new_v1 | new_v2;
      reuse   <= new_reuse;
      gap     <= GAP_NONE;
      dropped <= 1'b0;
    end else begin
      if (cmd.hit && (op == OP_SRC1 || op == OP_SRC2)) begin
        gap <= {1'b0, span};
      end
      if (cmd.miss && full) begin
        dropped <= 1'b1;
      end
    end
    if (cmd.finish) begin
      access_class <= acc;
      reuse_class  <= reuse;
      reuse_gap    <= gap;
      table_full   <= dropped;
    end
  end

endmodule

`default_nettype wire

/* rtl/reuse_distance_tracker.sv */
// top level of the reuse distance tracker
//
//  port group           dir  role
//  start/busy + src*/dest*  in   request, taken when start is high and busy low
//  done + result fields out  result, shown for the single cycle done is high
//
// a request keeps busy high while the sequencer picks each operand in turn; each
// variable operand adds a read and a compare state per table entry compared, and
// a further read state when it misses; the key table is scanned one entry at a
// time through its single registered read port, so a full table scans longest.
// reset clears the entry count and instruction index; no clearing pass.
// done follows busy falling, and a new request may be taken in that cycle.
// the receiver cannot stall; results are never held back.
`default_nettype none

module reuse_distance_tracker #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [rdt_pkg::KIND_W-1:0]       src1_kind,
  input  logic [rdt_pkg::KEY_W-1:0]        src1_key,
  input  logic [rdt_pkg::KIND_W-1:0]       src2_kind,
  input  logic [rdt_pkg::KEY_W-1:0]        src2_key,
  input  logic                             dest_is_variable,
  input  logic [rdt_pkg::KEY_W-1:0]        dest_key,
  output logic                             done,
  output logic                             access_class,
  output logic [1:0]                       reuse_class,
  output logic signed [rdt_pkg::GAP_W-1:0] reuse_gap,
  output logic                             table_full
);
  import rdt_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencer
  rdt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // table and result datapath
  rdt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .src1_kind        (src1_kind),
    .src1_key         (src1_key),
    .src2_kind        (src2_kind),
    .src2_key         (src2_key),
    .dest_is_variable (dest_is_variable),
    .dest_key         (dest_key),
    .done             (done),
    .access_class     (access_class),
    .reuse_class      (reuse_class),
    .reuse_gap        (reuse_gap),
    .table_full       (table_full)
  );

  // a result only appears once the sequencer is back to idle
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while busy");

  // an accepted request starts the sequencer
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // one result per request
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result repeated");

  // gap is either none or a non-negative distance
  assert property (@(posedge clk) disable iff (rst)
      done |-> (reuse_gap[GAP_W-1] == 1'b0 || reuse_gap == GAP_NONE))
    else $error("reuse gap out of range");

  // high reuse goes together with a variable source
  assert property (@(posedge clk) disable iff (rst)
      done |-> (access_class == (reuse_class == HINT_HIGH)))
    else $error("access and reuse classes disagree");

endmodule

`default_nettype wire
